@@ hw/rtl/hfrsv_pkg.sv @@
// hfrsv_pkg.sv: types, request codes and sizes for the hidden-flag rank/select vector
`timescale 1ns / 1ps

package hfrsv_pkg;

   // storage geometry
   localparam int CAPACITY   = 256;
   localparam int DIGIT_BITS = 16;
   localparam int NUM_DIGITS = CAPACITY / DIGIT_BITS;
   localparam int STEP_BITS  = $clog2(NUM_DIGITS);
   localparam int LANE_BITS  = $clog2(DIGIT_BITS);
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int COUNT_BITS = IDX_BITS + 1;
   localparam int POP_BITS   = LANE_BITS + 1;

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NUM_DIGITS - 1);

   // request codes
   localparam logic [3:0] REQ_INSERT     = 4'd0;
   localparam logic [3:0] REQ_REMOVE_VIS = 4'd1;
   localparam logic [3:0] REQ_REMOVE_OFF = 4'd2;
   localparam logic [3:0] REQ_REMOVE_HID = 4'd3;
   localparam logic [3:0] REQ_HIDE       = 4'd4;
   localparam logic [3:0] REQ_UNHIDE     = 4'd5;
   localparam logic [3:0] REQ_GET        = 4'd6;
   localparam logic [3:0] REQ_RANK       = 4'd7;
   localparam logic [3:0] REQ_CLEAR      = 4'd8;

   // insert kinds
   localparam logic [1:0] KIND_OFFSET  = 2'd0;
   localparam logic [1:0] KIND_VISIBLE = 2'd1;
   localparam logic [1:0] KIND_APPEND  = 2'd2;

   // status codes
   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_RANGE      = 3'd1;
   localparam logic [2:0] STAT_FULL       = 3'd2;
   localparam logic [2:0] STAT_NOT_FOUND  = 3'd3;
   localparam logic [2:0] STAT_HIDDEN     = 3'd4;
   localparam logic [2:0] STAT_NOT_HIDDEN = 3'd5;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE,
      OP_REMOVE_HID,
      OP_HIDE,
      OP_UNHIDE,
      OP_GET,
      OP_RANK,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic [3:0] req_type;
      logic [7:0] position;
      logic       hidden_flag;
      logic [1:0] insert_kind;
   } req_item_type;

   typedef struct packed {
      logic [7:0] result_position;
      logic       found;
      logic       was_hidden;
      logic [2:0] status;
      logic [8:0] total_count;
      logic [8:0] visible_count;
   } rsp_item_type;

endpackage

@@ hw/rtl/hidden_flag_rank_select_vector.sv @@
// hidden_flag_rank_select_vector.sv: ordered list of hidden flags with rank and select
`timescale 1ns / 1ps

// Ordered list of up to 256 entries, each with a hidden flag.
// Request channel (req_valid / req_stall / req_data) takes one request; the
// response channel (rsp_valid / rsp_stall / rsp_data) returns exactly one
// response per request, in order.
// The flags sit in a 256-bit ring that rotates one 16-bit digit per cycle
// while a request walks. Insert, remove, hide, unhide, get and rank pass
// every digit once, doing the offset compare, the select search, the shift
// and the counting on that digit alone, then pass through the finish state,
// which loads the response register; the next request is taken once the
// block is back in idle.
// Requests that fail their range or count checks, and clear all, skip the
// walk and go from idle straight to the finish state.
// The response sits in an output register, so a new request is accepted while
// the previous response waits. If the receiver stalls, a finished request
// waits in the finish state until the output register is free.
// Reset (synchronous, active high) empties the list and clears all flags.
module hidden_flag_rank_select_vector (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  hfrsv_pkg::req_item_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hfrsv_pkg::rsp_item_type rsp_data
);
   import hfrsv_pkg::*;

   state_type                state_ff, state_in;
   logic [CAPACITY-1:0]      ring_ff, ring_in;
   logic [COUNT_BITS-1:0]    entry_count_ff, entry_count_in;
   logic [COUNT_BITS-1:0]    hidden_count_ff, hidden_count_in;

   op_type                   op_ff;
   logic                     sel_mode_ff;
   logic [IDX_BITS-1:0]      key_ff;
   logic [2:0]               err_ff;
   logic                     ins_flag_ff;
   logic [STEP_BITS-1:0]     step_ff;
   logic                     past_ff, carry_ff, flag_ff, skip_ff;
   logic [COUNT_BITS-1:0]    off_ff, rank_ff;

   logic                     rsp_valid_ff;
   rsp_item_type             rsp_ff, rsp_in;

   logic                     req_take, walk_en, out_free, finish_fire;

   op_type                   dec_op;
   logic                     dec_sel;
   logic [IDX_BITS-1:0]      dec_key;
   logic [2:0]               dec_err;
   logic                     dec_walk;
   logic [COUNT_BITS-1:0]    vis_count;

   logic [DIGIT_BITS-1:0]    cur_digit, ge_mask, eq_mask, new_digit;
   logic [DIGIT_BITS-1:0]    shift_up, shift_down;
   logic                     next_bit, hit_here, flag_here, cond_fail, apply_now;
   logic [POP_BITS-1:0]      off_pop, rank_pop;

   assign vis_count = entry_count_ff - hidden_count_ff;

   // request decode and up-front checks
   always_comb begin
      logic [COUNT_BITS-1:0] pos9;
      logic                  exists;
      logic                  full;
      pos9     = {1'b0, req_data.position};
      exists   = pos9 < entry_count_ff;
      full     = entry_count_ff >= COUNT_BITS'(CAPACITY);
      dec_op   = OP_NONE;
      dec_sel  = 1'b0;
      dec_key  = req_data.position;
      dec_err  = STAT_OK;
      unique case (req_data.req_type)
         REQ_INSERT: begin
            dec_op = OP_INSERT;
            unique case (req_data.insert_kind)
               KIND_OFFSET: begin
                  if (pos9 > entry_count_ff) dec_err = STAT_RANGE;
               end
               KIND_VISIBLE: begin
                  if (pos9 > vis_count) begin
                     dec_err = STAT_RANGE;
                  end else if (pos9 == vis_count) begin
                     dec_key = entry_count_ff[IDX_BITS-1:0];
                  end else begin
                     dec_sel = 1'b1;
                  end
               end
               KIND_APPEND: begin
                  dec_key = entry_count_ff[IDX_BITS-1:0];
               end
               default: dec_err = STAT_RANGE;
            endcase
            if (dec_err == STAT_OK && full) dec_err = STAT_FULL;
         end
         REQ_REMOVE_VIS: begin
            dec_op  = OP_REMOVE;
            dec_sel = 1'b1;
            if (pos9 >= vis_count) dec_err = STAT_NOT_FOUND;
         end
         REQ_REMOVE_OFF: begin
            dec_op = OP_REMOVE;
            if (!exists) dec_err = STAT_NOT_FOUND;
         end
         REQ_REMOVE_HID: begin
            dec_op = OP_REMOVE_HID;
            if (!exists) dec_err = STAT_NOT_FOUND;
         end
         REQ_HIDE: begin
            dec_op = OP_HIDE;
            if (!exists) dec_err = STAT_NOT_FOUND;
         end
         REQ_UNHIDE: begin
            dec_op = OP_UNHIDE;
            if (!exists) dec_err = STAT_NOT_FOUND;
         end
         REQ_GET: begin
            dec_op = OP_GET;
            if (!exists) dec_err = STAT_NOT_FOUND;
         end
         REQ_RANK: begin
            dec_op = OP_RANK;
            if (!exists) dec_err = STAT_NOT_FOUND;
         end
         REQ_CLEAR: dec_op = OP_CLEAR;
         default:   dec_err = STAT_RANGE;
      endcase
      if (dec_err != STAT_OK) dec_op = OP_NONE;
      dec_walk = (dec_op != OP_NONE) && (dec_op != OP_CLEAR);
   end

   // state machine: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = dec_walk ? S_WALK : S_FINISH;
         end
         S_WALK: begin
            if (step_ff == LAST_STEP) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state machine: outputs
   always_comb begin
      req_stall   = 1'b1;
      walk_en     = 1'b0;
      finish_fire = 1'b0;
      unique case (state_ff)
         S_IDLE:   req_stall   = 1'b0;
         S_WALK:   walk_en     = 1'b1;
         S_FINISH: finish_fire = out_free;
         default:  req_stall   = 1'b1;
      endcase
   end

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // current digit and its neighbours
   assign cur_digit  = ring_ff[DIGIT_BITS-1:0];
   assign next_bit   = (step_ff == LAST_STEP) ? 1'b0 : ring_ff[DIGIT_BITS];
   assign shift_up   = {cur_digit[DIGIT_BITS-2:0], carry_ff};
   assign shift_down = {next_bit, cur_digit[DIGIT_BITS-1:1]};

   // lanes at or beyond the target: raw offset compare or visible-index select
   always_comb begin
      logic                  ge_raw;
      logic                  ge_sel;
      logic [COUNT_BITS-1:0] clear_thru;
      ge_raw     = 1'b0;
      ge_sel     = 1'b0;
      clear_thru = '0;
      for (int j = 0; j < DIGIT_BITS; j++) begin
         ge_raw     = {step_ff, LANE_BITS'(j)} >= key_ff;
         clear_thru = rank_ff + COUNT_BITS'($countones(~cur_digit &
                                 DIGIT_BITS'((1 << (j + 1)) - 1)));
         ge_sel     = past_ff || (clear_thru > {1'b0, key_ff});
         ge_mask[j] = sel_mode_ff ? ge_sel : ge_raw;
      end
   end

   assign eq_mask   = ge_mask & ~{ge_mask[DIGIT_BITS-2:0], past_ff};
   assign hit_here  = |eq_mask;
   assign flag_here = |(cur_digit & eq_mask);
   assign off_pop   = POP_BITS'($countones(~ge_mask));
   assign rank_pop  = POP_BITS'($countones(~ge_mask & ~cur_digit));

   // conditional requests that leave the list alone
   always_comb begin
      unique case (op_ff)
         OP_REMOVE_HID: cond_fail = !flag_here;
         OP_HIDE:       cond_fail = flag_here;
         OP_UNHIDE:     cond_fail = !flag_here;
         default:       cond_fail = 1'b0;
      endcase
   end

   assign apply_now = !skip_ff && !(hit_here && cond_fail);

   // rewrite of the current digit
   always_comb begin
      new_digit = cur_digit;
      unique case (op_ff)
         OP_INSERT: begin
            new_digit = (eq_mask & {DIGIT_BITS{ins_flag_ff}})
                      | (ge_mask & ~eq_mask & shift_up)
                      | (~ge_mask & cur_digit);
         end
         OP_REMOVE, OP_REMOVE_HID: begin
            if (apply_now) new_digit = (ge_mask & shift_down) | (~ge_mask & cur_digit);
         end
         OP_HIDE: begin
            if (apply_now) new_digit = cur_digit | eq_mask;
         end
         OP_UNHIDE: begin
            if (apply_now) new_digit = cur_digit & ~eq_mask;
         end
         default: new_digit = cur_digit;
      endcase
   end

   // ring rotation, and emptying on clear all
   always_comb begin
      ring_in = ring_ff;
      if (walk_en) begin
         ring_in = {new_digit, ring_ff[CAPACITY-1:DIGIT_BITS]};
      end else if (finish_fire && op_ff == OP_CLEAR) begin
         ring_in = '0;
      end
   end

   // response fields and updated counts
   always_comb begin
      entry_count_in  = entry_count_ff;
      hidden_count_in = hidden_count_ff;
      rsp_in          = '0;
      rsp_in.status   = STAT_OK;
      unique case (op_ff)
         OP_NONE: begin
            rsp_in.status = err_ff;
         end
         OP_CLEAR: begin
            entry_count_in  = '0;
            hidden_count_in = '0;
         end
         OP_INSERT: begin
            rsp_in.result_position = off_ff[IDX_BITS-1:0];
            rsp_in.found           = 1'b1;
            entry_count_in         = entry_count_ff + 1'b1;
            hidden_count_in        = hidden_count_ff + COUNT_BITS'(ins_flag_ff);
         end
         OP_REMOVE: begin
            rsp_in.result_position = off_ff[IDX_BITS-1:0];
            rsp_in.found           = 1'b1;
            rsp_in.was_hidden      = flag_ff;
            entry_count_in         = entry_count_ff - 1'b1;
            hidden_count_in        = hidden_count_ff - COUNT_BITS'(flag_ff);
         end
         OP_REMOVE_HID: begin
            rsp_in.result_position = off_ff[IDX_BITS-1:0];
            rsp_in.found           = 1'b1;
            rsp_in.was_hidden      = flag_ff;
            if (flag_ff) begin
               entry_count_in  = entry_count_ff - 1'b1;
               hidden_count_in = hidden_count_ff - 1'b1;
            end else begin
               rsp_in.status = STAT_NOT_HIDDEN;
            end
         end
         OP_HIDE: begin
            rsp_in.result_position = off_ff[IDX_BITS-1:0];
            rsp_in.found           = 1'b1;
            rsp_in.was_hidden      = flag_ff;
            if (flag_ff) rsp_in.status = STAT_HIDDEN;
            else hidden_count_in = hidden_count_ff + 1'b1;
         end
         OP_UNHIDE: begin
            rsp_in.result_position = off_ff[IDX_BITS-1:0];
            rsp_in.found           = 1'b1;
            rsp_in.was_hidden      = flag_ff;
            if (flag_ff) hidden_count_in = hidden_count_ff - 1'b1;
            else rsp_in.status = STAT_NOT_HIDDEN;
         end
         OP_GET: begin
            rsp_in.result_position = off_ff[IDX_BITS-1:0];
            rsp_in.found           = 1'b1;
            rsp_in.was_hidden      = flag_ff;
         end
         OP_RANK: begin
            if (flag_ff) begin
               rsp_in.was_hidden = 1'b1;
               rsp_in.status     = STAT_NOT_FOUND;
            end else begin
               rsp_in.result_position = rank_ff[IDX_BITS-1:0];
               rsp_in.found           = 1'b1;
            end
         end
         default: rsp_in.status = err_ff;
      endcase
      rsp_in.total_count   = entry_count_in;
      rsp_in.visible_count = entry_count_in - hidden_count_in;
   end

   // control state, flag ring and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         ring_ff         <= '0;
         entry_count_ff  <= '0;
         hidden_count_ff <= '0;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ring_ff  <= ring_in;
         if (walk_en) step_ff <= step_ff + 1'b1;
         if (finish_fire) begin
            entry_count_ff  <= entry_count_in;
            hidden_count_ff <= hidden_count_in;
         end
         if (finish_fire) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // request latch and per-digit accumulators
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff       <= dec_op;
         sel_mode_ff <= dec_sel;
         key_ff      <= dec_key;
         err_ff      <= dec_err;
         ins_flag_ff <= req_data.hidden_flag;
         past_ff     <= 1'b0;
         carry_ff    <= 1'b0;
         flag_ff     <= 1'b0;
         skip_ff     <= 1'b0;
         off_ff      <= '0;
         rank_ff     <= '0;
      end else if (walk_en) begin
         past_ff  <= ge_mask[DIGIT_BITS-1];
         carry_ff <= cur_digit[DIGIT_BITS-1];
         if (hit_here) flag_ff <= flag_here;
         skip_ff  <= skip_ff || (hit_here && cond_fail);
         off_ff   <= off_ff + COUNT_BITS'(off_pop);
         rank_ff  <= rank_ff + COUNT_BITS'(rank_pop);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (finish_fire) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // hidden entries never outnumber the entries held
   a_hidden_le_entries : assert property (@(posedge clock) disable iff (reset)
      hidden_count_ff <= entry_count_ff)
      else $error("hidden count exceeds entry count");

   // the list never grows past its capacity
   a_entries_le_capacity : assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= COUNT_BITS'(CAPACITY))
      else $error("entry count beyond capacity");

   // the ring is back at its home digit whenever a request can be taken
   a_ring_home_when_idle : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> step_ff == '0)
      else $error("digit ring not at home position while idle");

   // a finished request always shows up on the response channel
   a_finish_gives_response : assert property (@(posedge clock) disable iff (reset)
      finish_fire |=> rsp_valid)
      else $error("finished request produced no response");

endmodule
